@@ design/mrssc_pkg.sv @@
`default_nettype none

package mrssc_pkg;

    // Command codes
    localparam logic [2:0] CMD_TICK   = 3'd0;
    localparam logic [2:0] CMD_START  = 3'd1;
    localparam logic [2:0] CMD_STOP   = 3'd2;
    localparam logic [2:0] CMD_MODE   = 3'd3;
    localparam logic [2:0] CMD_DIRECT = 3'd4;
    localparam logic [2:0] CMD_FLOW   = 3'd5;

    // Speed modes
    localparam logic [1:0] MODE_LOW  = 2'd0;
    localparam logic [1:0] MODE_MID  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;
    localparam logic [1:0] MODE_RAMP = 2'd3;

    // Run states
    localparam logic [1:0] RS_STOPPED = 2'd0;
    localparam logic [1:0] RS_FIXED   = 2'd1;
    localparam logic [1:0] RS_UP      = 2'd2;
    localparam logic [1:0] RS_DOWN    = 2'd3;

    // Config register indexes
    localparam logic [1:0] REG_LIMIT_ONE   = 2'd0;
    localparam logic [1:0] REG_LIMIT_TWO   = 2'd1;
    localparam logic [1:0] REG_LIMIT_THREE = 2'd2;
    localparam logic [1:0] REG_LIMIT_FOUR  = 2'd3;

    localparam logic [11:0] LIMIT_ONE_RST   = 12'd1024;
    localparam logic [11:0] LIMIT_TWO_RST   = 12'd2048;
    localparam logic [11:0] LIMIT_THREE_RST = 12'd3072;
    localparam logic [11:0] LIMIT_FOUR_RST  = 12'd4095;

    localparam logic [10:0] DUTY_LOW  = 11'd498;
    localparam logic [10:0] DUTY_MID  = 11'd655;
    localparam logic [10:0] DUTY_HIGH = 11'd811;
    localparam logic [10:0] DUTY_MAX  = 11'd2047;
    localparam logic [15:0] RPM_MAX   = 16'd2650;
    localparam logic [8:0]  RAMP_DEFAULT_STEP = 9'd5;
    localparam logic [15:0] STALL_MIN_PULSES  = 16'd2;
    localparam logic [1:0]  STALL_WINDOWS_MAX = 2'd3;
    localparam logic [2:0]  LEVEL_MAX = 3'd4;

    localparam int WINDOW_PERIODS_DEF   = 20;
    localparam int DEBOUNCE_PERIODS_DEF = 4;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [1:0]  speed_mode;
        logic [15:0] direct_rpm;
        logic [2:0]  flow_seconds;
        logic [7:0]  tach_pulses;
        logic [11:0] current_sample;
    } t_in;

    typedef struct packed {
        logic [10:0] duty_value;
        logic        duty_written;
        logic        stall_event;
        logic        level_changed;
        logic [2:0]  current_level;
        logic [1:0]  run_mode;
    } t_out;

    // Duty of a fixed speed mode
    function automatic logic [10:0] fixed_duty(input logic [1:0] mode);
        logic [10:0] d;
        case (mode)
            MODE_LOW: d = DUTY_LOW;
            MODE_MID: d = DUTY_MID;
            default:  d = DUTY_HIGH;
        endcase
        return d;
    endfunction

    // Ramp step for 1..5 seconds: (811 - 498) / seconds
    function automatic logic [8:0] flow_step(input logic [2:0] secs);
        logic [8:0] s;
        case (secs)
            3'd1:    s = 9'd313;
            3'd2:    s = 9'd156;
            3'd3:    s = 9'd104;
            3'd4:    s = 9'd78;
            default: s = 9'd62;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

@@ design/motor_ramp_stall_current_supervisor.sv @@
// Motor ramp, stall and current supervisor.
// Input channel: one command beat per accept (i_in_valid high, o_in_stall low).
// A tick beat carries one control period's tach pulses and current sample;
// start, stop, mode change, direct speed and flow time beats update the drive.
// Output channel: exactly one result beat per command, in order, handshaked by
// o_out_valid / i_out_stall, carrying duty, write/stall/level flags and state.
// The result passes through the input register, then the result register that
// also commits the state. Throughput: one beat per cycle while the receiver
// does not stall; the state update is a single pass of compares and adds.
// Current limits are written through i_cfg_we/i_cfg_index/i_cfg_data; the user
// writes them only while no command is in flight; the block does not enforce it.
// Reset (synchronous, active low) stops the motor, clears all counters and the
// shown level, and restores the default current limits.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more beat, and o_in_stall then rises until the
// result is taken.
`default_nettype none

module motor_ramp_stall_current_supervisor
    import mrssc_pkg::*;
#(
    parameter int WINDOW_PERIODS   = WINDOW_PERIODS_DEF,
    parameter int DEBOUNCE_PERIODS = DEBOUNCE_PERIODS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in         i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out             o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);

    localparam int WW = $clog2(WINDOW_PERIODS + 2);
    localparam int DW = $clog2(DEBOUNCE_PERIODS + 1);

    // Config registers
    logic [11:0] r_lim1, r_lim2, r_lim3, r_lim4;

    // Pipeline registers
    logic  r_s1_valid;
    t_in   r_s1;
    logic  r_out_valid;
    t_out  r_out;

    // Supervisor state
    logic [1:0]    r_run_state, n_run_state;
    logic [10:0]   r_duty_now, n_duty_now;
    logic [10:0]   r_duty_goal, n_duty_goal;
    logic [8:0]    r_ramp_step, n_ramp_step;
    logic [WW-1:0] r_win, n_win;
    logic [15:0]   r_pulse_total, n_pulse_total;
    logic [1:0]    r_stall_windows, n_stall_windows;
    logic [2:0]    r_shown, n_shown;
    logic [DW-1:0] r_mis, n_mis;
    t_out          n_out;

    logic out_ready, adv;

    assign out_ready   = !r_out_valid || !i_out_stall;
    assign adv         = r_s1_valid && out_ready;
    assign o_in_stall  = r_s1_valid && !out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim1 <= LIMIT_ONE_RST;
            r_lim2 <= LIMIT_TWO_RST;
            r_lim3 <= LIMIT_THREE_RST;
            r_lim4 <= LIMIT_FOUR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LIMIT_ONE:   r_lim1 <= i_cfg_data;
                REG_LIMIT_TWO:   r_lim2 <= i_cfg_data;
                REG_LIMIT_THREE: r_lim3 <= i_cfg_data;
                REG_LIMIT_FOUR:  r_lim4 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next-state and result for the beat in the input register
    logic [16:0]   pulse_sum;
    logic [WW-1:0] win_inc;
    logic [11:0]   duty_sum;
    logic [2:0]    lvl;
    logic [DW-1:0] mis_inc;
    logic [11:0]   rpm_clamp;
    logic [15:0]   rpm_x10;
    logic          written, stall, changed;

    always_comb begin
        n_run_state     = r_run_state;
        n_duty_now      = r_duty_now;
        n_duty_goal     = r_duty_goal;
        n_ramp_step     = r_ramp_step;
        n_win           = r_win;
        n_pulse_total   = r_pulse_total;
        n_stall_windows = r_stall_windows;
        n_shown         = r_shown;
        n_mis           = r_mis;
        written         = 1'b0;
        stall           = 1'b0;
        changed         = 1'b0;

        pulse_sum = {1'b0, r_pulse_total} + {9'd0, r_s1.tach_pulses};
        win_inc   = r_win + WW'(1);
        duty_sum  = {1'b0, r_duty_now} + {3'd0, r_ramp_step};
        mis_inc   = r_mis + DW'(1);

        if (r_s1.current_sample >= r_lim4)      lvl = 3'd4;
        else if (r_s1.current_sample >= r_lim3) lvl = 3'd3;
        else if (r_s1.current_sample >= r_lim2) lvl = 3'd2;
        else if (r_s1.current_sample >= r_lim1) lvl = 3'd1;
        else                                    lvl = 3'd0;

        rpm_clamp = (r_s1.direct_rpm > RPM_MAX) ? RPM_MAX[11:0] : r_s1.direct_rpm[11:0];
        rpm_x10   = {4'd0, rpm_clamp} * 16'd10;

        case (r_s1.cmd)
            CMD_TICK: begin
                n_pulse_total = pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
                if (r_run_state != RS_STOPPED) begin
                    // stall window
                    if (win_inc > WW'(WINDOW_PERIODS)) begin
                        n_win = '0;
                        if (n_pulse_total < STALL_MIN_PULSES) begin
                            if (r_stall_windows + 2'd1 >= STALL_WINDOWS_MAX) begin
                                n_stall_windows = 2'd0;
                                stall           = 1'b1;
                            end else begin
                                n_stall_windows = r_stall_windows + 2'd1;
                            end
                        end else begin
                            n_stall_windows = 2'd0;
                        end
                        n_pulse_total = '0;
                    end else begin
                        n_win = win_inc;
                    end
                    // ramp step
                    if (r_run_state == RS_UP) begin
                        if (r_duty_now < r_duty_goal) begin
                            n_duty_now = duty_sum[11] ? DUTY_MAX : duty_sum[10:0];
                        end else begin
                            n_duty_goal = DUTY_LOW;
                            n_duty_now  = DUTY_HIGH;
                            n_run_state = RS_DOWN;
                        end
                        written = 1'b1;
                    end else if (r_run_state == RS_DOWN) begin
                        if (r_duty_now > r_duty_goal) begin
                            n_duty_now = (r_duty_now > {2'd0, r_ramp_step})
                                       ? r_duty_now - {2'd0, r_ramp_step} : 11'd0;
                        end else begin
                            n_duty_goal = DUTY_HIGH;
                            n_duty_now  = DUTY_LOW;
                            n_run_state = RS_UP;
                        end
                        written = 1'b1;
                    end
                    // level debounce
                    if (lvl != r_shown) begin
                        if (mis_inc >= DW'(DEBOUNCE_PERIODS)) begin
                            n_mis = '0;
                            if (lvl >= r_shown) begin
                                if (r_shown < LEVEL_MAX) n_shown = r_shown + 3'd1;
                            end else if (r_shown != 3'd0) begin
                                n_shown = r_shown - 3'd1;
                            end
                            changed = 1'b1;
                        end else begin
                            n_mis = mis_inc;
                        end
                    end else begin
                        n_mis = '0;
                    end
                end
            end
            CMD_START: begin
                if (r_s1.speed_mode == MODE_RAMP) begin
                    n_duty_now  = DUTY_LOW;
                    n_duty_goal = DUTY_HIGH;
                    n_ramp_step = RAMP_DEFAULT_STEP;
                    n_run_state = RS_UP;
                end else begin
                    n_duty_now  = fixed_duty(r_s1.speed_mode);
                    n_duty_goal = fixed_duty(r_s1.speed_mode);
                    n_run_state = RS_FIXED;
                end
                written         = 1'b1;
                n_pulse_total   = '0;
                n_win           = '0;
                n_stall_windows = 2'd0;
            end
            CMD_STOP: begin
                n_duty_now  = '0;
                n_duty_goal = '0;
                n_shown     = 3'd0;
                n_run_state = RS_STOPPED;
                written     = 1'b1;
            end
            CMD_MODE: begin
                if (r_s1.speed_mode == MODE_RAMP) begin
                    // duty register is written on the next tick
                    n_duty_now  = DUTY_HIGH;
                    n_duty_goal = DUTY_LOW;
                    n_ramp_step = RAMP_DEFAULT_STEP;
                    n_run_state = RS_DOWN;
                end else begin
                    n_duty_now  = fixed_duty(r_s1.speed_mode);
                    n_duty_goal = fixed_duty(r_s1.speed_mode);
                    n_run_state = RS_FIXED;
                    written     = 1'b1;
                end
                n_pulse_total = '0;
                n_win         = '0;
            end
            CMD_DIRECT: begin
                // duty = rpm * 10 / 32
                n_duty_now  = rpm_x10[15:5];
                n_duty_goal = rpm_x10[15:5];
                written     = 1'b1;
            end
            CMD_FLOW: begin
                if (r_s1.flow_seconds >= 3'd1 && r_s1.flow_seconds <= 3'd5)
                    n_ramp_step = flow_step(r_s1.flow_seconds);
            end
            default: ;
        endcase

        n_out.duty_value    = n_duty_now;
        n_out.duty_written  = written;
        n_out.stall_event   = stall;
        n_out.level_changed = changed;
        n_out.current_level = n_shown;
        n_out.run_mode      = n_run_state;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_s1 <= i_in_data;
        end
    end

    // Result register and state commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid     <= 1'b0;
            r_run_state     <= RS_STOPPED;
            r_duty_now      <= '0;
            r_duty_goal     <= '0;
            r_ramp_step     <= '0;
            r_win           <= '0;
            r_pulse_total   <= '0;
            r_stall_windows <= '0;
            r_shown         <= '0;
            r_mis           <= '0;
        end else begin
            if (out_ready) begin
                r_out_valid <= r_s1_valid;
            end
            if (adv) begin
                r_run_state     <= n_run_state;
                r_duty_now      <= n_duty_now;
                r_duty_goal     <= n_duty_goal;
                r_ramp_step     <= n_ramp_step;
                r_win           <= n_win;
                r_pulse_total   <= n_pulse_total;
                r_stall_windows <= n_stall_windows;
                r_shown         <= n_shown;
                r_mis           <= n_mis;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    // Checks
    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shown <= LEVEL_MAX)
        else $error("shown level out of range");

    a_stall_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.stall_event) |-> (r_out.run_mode != RS_STOPPED))
        else $error("stall event while stopped");

    a_stall_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stall_windows != STALL_WINDOWS_MAX)
        else $error("stall window count not cleared");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_duty_now) && $stable(r_run_state))
        else $error("state changed without a beat");

endmodule

`default_nettype wire
